>>> rtl/core/dws_pkg.sv
// package for the deque with search: sizes, codes and ring index helper
`default_nettype none

package dws_pkg;

  // ring size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK    = 3'd0,
    MODE_PUSH_FRONT   = 3'd1,
    MODE_POP_FRONT    = 3'd2,
    MODE_POP_BACK     = 3'd3,
    MODE_SEARCH_FRONT = 3'd4,
    MODE_SEARCH_BACK  = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // one result item
  typedef struct packed {
    status_e          status;
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] occupancy;
  } result_t;

  // fold a sum below twice the capacity back into the ring
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] folded;
    folded = (sum >= SUM_W'(CAPACITY)) ? (sum - SUM_W'(CAPACITY)) : sum;
    return folded[IDX_W-1:0];
  endfunction

  // count to the 5-bit result field, masked when the count is wider
  function automatic logic [POS_W-1:0] to_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, cnt};
    return ext[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dws_if.sv
// handshake interfaces for the operation and result channels
`default_nettype none

interface dws_in_if
  import dws_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface dws_out_if
  import dws_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  occupancy;

  modport source (output valid, output status, output found, output position,
                  output occupancy, input ready);
  modport sink (input valid, input status, input found, input position,
                input occupancy, output ready);
endinterface

`default_nettype wire

>>> rtl/core/deque_with_search.sv
// deque with search: ring of entries in a ram, walked one entry a cycle on search
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode, value
//   out_o    out  valid/ready    status, found, position, occupancy
//
// push, pop and no-op items are accepted, then handed to the output register.
// a search walks the n held entries, stopping early on a match; the
// single ram read port allows one entry read and compared per cycle.
// reset clears front index, count and control; the ram holds no reset state.
// a new item is taken while a result waits in the output register; a stalled
// output holds the next result in the done state until the register frees.
`default_nettype none

module deque_with_search
  import dws_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dws_in_if.sink    in_i,
  dws_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0]  cmp_pos_q, cmp_pos_d;
  logic              cmp_v_q, cmp_v_d;
  logic              from_back_q, from_back_d;
  logic [DATA_W-1:0] key_q, key_d;
  result_t           pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              accept;
  logic              full, empty;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              hit, issue, walk_end, out_load;
  logic [CNT_W-1:0]  back_off;

  assign accept = in_i.valid && in_i.ready;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);

  // entry storage
  dws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_d),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search walk: compare stage against the key, read stage ahead of it
  assign hit      = (state_q == ST_SEARCH) && cmp_v_q && (ram_rdata == key_q);
  assign walk_end = (state_q == ST_SEARCH) && !hit && (rd_cnt_q == count_q);
  assign issue    = (state_q == ST_SEARCH) && !hit && (rd_cnt_q != count_q);
  assign back_off = count_q - CNT_W'(1) - rd_cnt_q;
  assign ram_re   = issue;
  assign ram_raddr = from_back_q ? ring_wrap({1'b0, front_q} + SUM_W'(back_off))
                                 : ring_wrap({1'b0, front_q} + SUM_W'(rd_cnt_q));

  // output register frees when empty or drained this cycle
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // item decode, state update and sequencing
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_pos_d   = cmp_pos_q;
    cmp_v_d     = issue;
    from_back_d = from_back_q;
    key_d       = in_i.value;
    pend_d      = pend_q;
    ram_we      = 1'b0;
    ram_waddr   = ring_wrap({1'b0, front_q} + SUM_W'(count_q));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_d.status   = STATUS_DONE;
          pend_d.found    = 1'b0;
          pend_d.position = '0;
          state_d         = ST_DONE;
          case (mode_e'(in_i.mode))
            MODE_PUSH_BACK: begin
              if (full) begin
                pend_d.status = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_PUSH_FRONT: begin
              ram_waddr = ring_wrap({1'b0, front_q} + SUM_W'(CAPACITY - 1));
              if (full) begin
                pend_d.status = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                front_d = ram_waddr;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                pend_d.status = STATUS_EMPTY;
              end else begin
                front_d = ring_wrap({1'b0, front_q} + SUM_W'(1));
                count_d = count_q - CNT_W'(1);
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                pend_d.status = STATUS_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            MODE_SEARCH_FRONT, MODE_SEARCH_BACK: begin
              from_back_d = (mode_e'(in_i.mode) == MODE_SEARCH_BACK);
              rd_cnt_d    = '0;
              state_d     = ST_SEARCH;
            end
            default: begin
            end
          endcase
          pend_d.occupancy = to_field(count_d);
        end
      end
      ST_SEARCH: begin
        key_d = key_q;
        if (issue) begin
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          cmp_pos_d = rd_cnt_q + CNT_W'(1);
        end
        if (hit) begin
          pend_d.found    = 1'b1;
          pend_d.position = to_field(cmp_pos_q);
          state_d         = ST_DONE;
        end else if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        key_d = key_q;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = pend_q;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_q.status;
  assign out_o.found     = out_q.found;
  assign out_o.position  = out_q.position;
  assign out_o.occupancy = out_q.occupancy;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_pos_q   <= cmp_pos_d;
    from_back_q <= from_back_d;
    key_q       <= key_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < SUM_W'(CAPACITY))
    else $error("front index outside ring");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (rd_cnt_q < count_q))
    else $error("search read beyond held entries");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (in_i.mode == MODE_PUSH_BACK || in_i.mode == MODE_PUSH_FRONT))
      |=> ($stable(count_q) && $stable(front_q)))
    else $error("refused push changed the ring");

  a_search_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> $stable(count_q))
    else $error("count moved during a search");

endmodule

`default_nettype wire

>>> rtl/core/dws_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
